// ===== src/lr_pkg.sv =====
// shared constants, types and helpers for the line rasterizer
`timescale 1ns / 1ps
package lr_pkg;

  localparam int COORD_BITS  = 12;
  localparam int DIM_BITS    = 11;
  localparam int DELTA_BITS  = COORD_BITS + 1;
  localparam int ERR_BITS    = COORD_BITS + 4;
  localparam int COLOR_BITS  = 16;
  localparam int CMP_BITS    = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = QPTR_BITS + 1;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_DISP_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DISP_HEIGHT = 1'b1;

  localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(160);
  localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(128);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [DELTA_BITS-1:0] delta_t;
  typedef logic signed [ERR_BITS-1:0]   err_t;
  typedef logic        [COLOR_BITS-1:0] color_t;
  typedef logic        [DIM_BITS-1:0]   dim_t;

  // one classified transaction as it sits in the queue
  typedef struct packed {
    logic   step;
    logic   steep;
    coord_t major_pos;
    coord_t major_end;
    coord_t minor_pos;
    logic   minor_neg;
    delta_t delta_major;
    delta_t delta_minor;
    err_t   error_term;
    color_t color;
  } line_cmd_t;

  function automatic logic in_range(coord_t v, dim_t limit);
    logic [CMP_BITS-1:0] a;
    logic [CMP_BITS-1:0] b;
    a = CMP_BITS'($unsigned(v));
    b = CMP_BITS'(limit);
    return !v[COORD_BITS-1] && (a < b);
  endfunction

endpackage

// ===== src/lr_front.sv =====
// front end: accepts input transactions and works out the line setup
`timescale 1ns / 1ps
module lr_front import lr_pkg::*; (
  input  logic      item_valid,
  output logic      item_stall,
  input  logic      action,
  input  coord_t    start_x,
  input  coord_t    start_y,
  input  coord_t    end_x,
  input  coord_t    end_y,
  input  color_t    draw_color,
  input  logic      queue_full,
  output logic      push,
  output line_cmd_t cmd
);

  logic signed [DELTA_BITS-1:0] dx;
  logic signed [DELTA_BITS-1:0] dy;
  delta_t adx;
  delta_t ady;
  logic   steep;
  logic   swap;
  coord_t maj0;
  coord_t maj1;
  coord_t min0;
  coord_t min1;
  delta_t dmaj;
  delta_t dmin;

  always_comb begin
    dx = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
    dy = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
    adx = dx[DELTA_BITS-1] ? delta_t'(-dx) : delta_t'(dx);
    ady = dy[DELTA_BITS-1] ? delta_t'(-dy) : delta_t'(dy);
    // ties go to the steep form
    steep = !(ady < adx);
    maj0 = steep ? start_y : start_x;
    maj1 = steep ? end_y   : end_x;
    min0 = steep ? start_x : start_y;
    min1 = steep ? end_x   : end_y;
    // swap decided from the raw endpoints so the compares run in parallel
    swap = steep ? (start_y > end_y) : (start_x > end_x);
    dmaj = steep ? ady : adx;
    dmin = steep ? adx : ady;

    cmd.step        = (action == ACT_STEP);
    cmd.steep       = steep;
    cmd.major_pos   = swap ? maj1 : maj0;
    cmd.major_end   = swap ? maj0 : maj1;
    cmd.minor_pos   = swap ? min1 : min0;
    cmd.minor_neg   = swap ? (min0 < min1) : (min1 < min0);
    cmd.delta_major = dmaj;
    cmd.delta_minor = dmin;
    cmd.error_term  = $signed(ERR_BITS'({dmin, 1'b0})) - $signed(ERR_BITS'(dmaj));
    cmd.color       = draw_color;
  end

  assign item_stall = queue_full;
  assign push       = item_valid && !queue_full;

endmodule

// ===== src/lr_queue.sv =====
// short command queue between the front end and the stepper
`timescale 1ns / 1ps
module lr_queue import lr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  line_cmd_t push_cmd,
  input  logic      pop,
  output logic      full,
  output logic      not_empty,
  output line_cmd_t head
);

  line_cmd_t entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wptr;
  logic [QPTR_BITS-1:0] rptr;
  logic [QCNT_BITS-1:0] count;

  assign full      = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rptr <= rptr + QPTR_BITS'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_BITS'(1);
        2'b01:   count <= count - QCNT_BITS'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/lr_back.sv =====
// back end: bresenham stepper, screen registers and pixel output register
`timescale 1ns / 1ps
module lr_back import lr_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  input  line_cmd_t                 head,
  output logic                      pop,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  dim_t                      cfg_data,
  output logic                      pixel_valid,
  input  logic                      pixel_stall,
  output coord_t                    pixel_x,
  output coord_t                    pixel_y,
  output color_t                    pixel_color,
  output logic                      on_screen,
  output logic                      last_pixel
);

  dim_t disp_width;
  dim_t disp_height;

  logic   busy;
  logic   steep;
  coord_t major_pos;
  coord_t major_end;
  coord_t minor_pos;
  logic   minor_neg;
  delta_t delta_major;
  delta_t delta_minor;
  err_t   error_term;
  color_t held_color;

  logic   steep_next;
  coord_t major_pos_next;
  coord_t major_end_next;
  coord_t minor_pos_next;
  logic   minor_neg_next;
  delta_t delta_major_next;
  delta_t delta_minor_next;
  err_t   error_term_next;
  color_t held_color_next;
  logic   busy_next;

  logic   take;
  logic   emit;
  logic   last;
  coord_t px;
  coord_t py;
  err_t   two_min;
  err_t   two_maj;

  always_ff @(posedge clk) begin
    if (rst) begin
      disp_width  <= WIDTH_RESET;
      disp_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      if (cfg_index == CFG_DISP_WIDTH) begin
        disp_width <= cfg_data;
      end
      if (cfg_index == CFG_DISP_HEIGHT) begin
        disp_height <= cfg_data;
      end
    end
  end

  // output register frees up when empty or being taken this cycle
  assign take = !pixel_valid || !pixel_stall;
  assign pop  = q_valid && take;

  always_comb begin
    steep_next       = steep;
    major_pos_next   = major_pos;
    major_end_next   = major_end;
    minor_pos_next   = minor_pos;
    minor_neg_next   = minor_neg;
    delta_major_next = delta_major;
    delta_minor_next = delta_minor;
    error_term_next  = error_term;
    held_color_next  = held_color;
    emit             = 1'b0;
    two_min = $signed(ERR_BITS'({delta_minor, 1'b0}));
    two_maj = $signed(ERR_BITS'({delta_major, 1'b0}));
    if (!head.step) begin
      steep_next       = head.steep;
      major_pos_next   = head.major_pos;
      major_end_next   = head.major_end;
      minor_pos_next   = head.minor_pos;
      minor_neg_next   = head.minor_neg;
      delta_major_next = head.delta_major;
      delta_minor_next = head.delta_minor;
      error_term_next  = head.error_term;
      held_color_next  = head.color;
      emit             = 1'b1;
    end else if (busy) begin
      if (error_term > 0) begin
        minor_pos_next  = minor_neg ? minor_pos - COORD_BITS'(1)
                                    : minor_pos + COORD_BITS'(1);
        error_term_next = error_term + two_min - two_maj;
      end else begin
        error_term_next = error_term + two_min;
      end
      major_pos_next = major_pos + COORD_BITS'(1);
      emit           = 1'b1;
    end
    // a step while idle is swallowed with no pixel
    last      = !(major_pos_next < major_end_next);
    busy_next = emit ? !last : busy;
    px = steep_next ? minor_pos_next : major_pos_next;
    py = steep_next ? major_pos_next : minor_pos_next;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      steep       <= steep_next;
      major_pos   <= major_pos_next;
      major_end   <= major_end_next;
      minor_pos   <= minor_pos_next;
      minor_neg   <= minor_neg_next;
      delta_major <= delta_major_next;
      delta_minor <= delta_minor_next;
      error_term  <= error_term_next;
      held_color  <= held_color_next;
    end
    if (pop && emit) begin
      pixel_x     <= px;
      pixel_y     <= py;
      pixel_color <= held_color_next;
      on_screen   <= in_range(px, disp_width) && in_range(py, disp_height);
      last_pixel  <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      pixel_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= busy_next;
      end
      if (take) begin
        pixel_valid <= pop && emit;
      end
    end
  end

endmodule

// ===== src/line_rasterizer_core.sv =====
// top level of the bresenham line rasterizer
//
// input channel (item_valid / item_stall): action 0 starts a line from
// start_x/start_y to end_x/end_y in draw_color and yields its first pixel;
// action 1 yields the next pixel of the current line, or nothing when no
// line is in progress. a start during a line drops the old one.
// output channel (pixel_valid / pixel_stall): at most one pixel per transaction with
// its coordinates, colour, an on_screen flag against the display width and
// height registers, and last_pixel on the final point of the line.
// config port: cfg_write with cfg_index 0 sets the display width, 1 sets
// the display height; write only while the block is idle.
// an accepted item goes through the command queue and then through the
// stepper into the output register. throughput is one item per cycle
// while the receiver does not stall. the queue holds four commands, so
// the input keeps taking items for a while after the receiver stalls; the
// output register holds its pixel steady while stalled.
// reset clears the queue, the line-in-progress flag and the output valid, and loads
// the screen size 160 x 128.
`timescale 1ns / 1ps
module line_rasterizer_core import lr_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic                      action,
  input  coord_t                    start_x,
  input  coord_t                    start_y,
  input  coord_t                    end_x,
  input  coord_t                    end_y,
  input  color_t                    draw_color,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  dim_t                      cfg_data,
  output logic                      pixel_valid,
  input  logic                      pixel_stall,
  output coord_t                    pixel_x,
  output coord_t                    pixel_y,
  output color_t                    pixel_color,
  output logic                      on_screen,
  output logic                      last_pixel
);

  logic      push;
  logic      pop;
  logic      queue_full;
  logic      queue_valid;
  line_cmd_t push_cmd;
  line_cmd_t head_cmd;

  lr_front u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .action     (action),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .draw_color (draw_color),
    .queue_full (queue_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  lr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (queue_full),
    .not_empty (queue_valid),
    .head      (head_cmd)
  );

  lr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (queue_valid),
    .head        (head_cmd),
    .pop         (pop),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .on_screen   (on_screen),
    .last_pixel  (last_pixel)
  );

endmodule

// ===== src/lr_checker.sv =====
// port-level checks for the line rasterizer and the bind that attaches them
`timescale 1ns / 1ps
module lr_checker import lr_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   pixel_valid,
  input logic   pixel_stall,
  input coord_t pixel_x,
  input coord_t pixel_y,
  input color_t pixel_color,
  input logic   on_screen,
  input logic   last_pixel
);

  // a stalled pixel stays put
  a_pixel_hold: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel_x) && $stable(pixel_y)
      && $stable(pixel_color) && $stable(on_screen) && $stable(last_pixel))
    else $error("pixel changed while stalled");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !pixel_valid)
    else $error("pixel valid after reset");

  // negative coordinates are never on screen
  a_clip_sign: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && on_screen |-> !pixel_x[COORD_BITS-1] && !pixel_y[COORD_BITS-1])
    else $error("negative pixel flagged on screen");

endmodule

bind line_rasterizer_core lr_checker u_lr_checker (
  .clk         (clk),
  .rst         (rst),
  .pixel_valid (pixel_valid),
  .pixel_stall (pixel_stall),
  .pixel_x     (pixel_x),
  .pixel_y     (pixel_y),
  .pixel_color (pixel_color),
  .on_screen   (on_screen),
  .last_pixel  (last_pixel)
);
